// File: rtl/radix_tree_node_builder_top_assert.svh
// Assertion macros for the radix tree node builder.
// Each macro takes a label, clock, active-low reset, condition, consequence and message.
`ifndef RADIX_TREE_NODE_BUILDER_TOP_ASSERT_SVH
`define RADIX_TREE_NODE_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RTNB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTNB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rtnb_pkg.sv
// ----------------------------------------------------------------------------
// rtnb_pkg
// Shared types, constants and the prefix-length function of the node builder.
// ----------------------------------------------------------------------------
package rtnb_pkg;

    localparam int IDX_W    = 10;
    localparam int KEY_W    = 64;
    localparam int CNT_W    = 11;
    localparam int PFX_W    = 8;
    localparam int MAX_KEYS = 1024;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_BUILD = 1'b1;

    localparam logic [CNT_W-1:0] KEY_COUNT_RST = 11'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_KI,
        OP_LATCH_KI,
        OP_PROBE,
        OP_DIR_A,
        OP_DIR_B,
        OP_LIM,
        OP_FAR,
        OP_DN,
        OP_SPL,
        OP_OUT
    } t_dp_op;

    // Which key position a probe reads.
    typedef enum logic [2:0] {
        POS_I,
        POS_P1,
        POS_M1,
        POS_LIM,
        POS_FAR,
        POS_J,
        POS_SPL
    } t_pos_sel;

    typedef struct packed {
        t_dp_op   op;
        t_pos_sel sel;
    } t_cmd;

    typedef struct packed {
        logic node_ok;
        logic is_build;
        logic dir_zero;
        logic hit_dmin;
        logic hit_dnode;
        logic t_gt1;
    } t_stat;

    // Number of equal leading bits of two keys, 64 when they are equal.
    function automatic logic signed [PFX_W-1:0] prefix_len(
        input logic [KEY_W-1:0] a,
        input logic [KEY_W-1:0] b
    );
        logic [KEY_W-1:0]         x;
        logic signed [PFX_W-1:0]  n;
        x = a ^ b;
        n = PFX_W'(KEY_W);
        for (int k = 0; k < KEY_W; k++) begin
            if (x[k]) begin
                n = PFX_W'(KEY_W - 1 - k);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/rtnb_if.sv
// ----------------------------------------------------------------------------
// rtnb interfaces
// Valid/ready channels for input items, results and the configuration write.
// ----------------------------------------------------------------------------
interface rtnb_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [9:0]  index;
    logic [63:0] key;
    modport source (output valid, func, index, key, input ready);
    modport sink   (input valid, func, index, key, output ready);
endinterface

interface rtnb_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] node_index;
    logic [9:0] left_child;
    logic       left_is_leaf;
    logic [9:0] right_child;
    logic       right_is_leaf;
    logic       duplicate_error;
    modport source (output valid, node_index, left_child, left_is_leaf, right_child,
                    right_is_leaf, duplicate_error, input ready);
    modport sink   (input valid, node_index, left_child, left_is_leaf, right_child,
                    right_is_leaf, duplicate_error, output ready);
endinterface

interface rtnb_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] key_count;
    modport source (output valid, key_count, input ready);
    modport sink   (input valid, key_count, output ready);
endinterface

// File: rtl/rtnb_ram.sv
// ----------------------------------------------------------------------------
// rtnb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtnb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rtnb_ctrl.sv
// ----------------------------------------------------------------------------
// rtnb_ctrl
// Sequencer that steps the datapath through direction, bound, far-end and
// split searches, one key probe at a time.
// ----------------------------------------------------------------------------
module rtnb_ctrl
    import rtnb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_KI_RD, S_KI_WT, S_DA_AD, S_DA_DT, S_DB_AD, S_DB_DT,
        S_LM_AD, S_LM_DT, S_FR_AD, S_FR_DT, S_DN_AD, S_DN_DT,
        S_SP_AD, S_SP_DT, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The input side only takes beats while idle and out of reset.
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = POS_I;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_st.is_build && i_st.node_ok) begin
                        n_state = S_KI_RD;
                    end
                end
            end
            S_KI_RD: begin
                o_cmd.op = OP_RD_KI;
                n_state  = S_KI_WT;
            end
            S_KI_WT: begin
                o_cmd.op = OP_LATCH_KI;
                n_state  = S_DA_AD;
            end
            S_DA_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_P1;
                n_state   = S_DA_DT;
            end
            S_DA_DT: begin
                o_cmd.op = OP_DIR_A;
                n_state  = S_DB_AD;
            end
            S_DB_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_M1;
                n_state   = S_DB_DT;
            end
            S_DB_DT: begin
                o_cmd.op = OP_DIR_B;
                n_state  = i_st.dir_zero ? S_FIN : S_LM_AD;
            end
            S_LM_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_LIM;
                n_state   = S_LM_DT;
            end
            S_LM_DT: begin
                o_cmd.op = OP_LIM;
                n_state  = i_st.hit_dmin ? S_LM_AD : S_FR_AD;
            end
            S_FR_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_FAR;
                n_state   = S_FR_DT;
            end
            S_FR_DT: begin
                o_cmd.op = OP_FAR;
                n_state  = i_st.t_gt1 ? S_FR_AD : S_DN_AD;
            end
            S_DN_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_J;
                n_state   = S_DN_DT;
            end
            S_DN_DT: begin
                o_cmd.op = OP_DN;
                n_state  = S_SP_AD;
            end
            S_SP_AD: begin
                o_cmd.op  = OP_PROBE;
                o_cmd.sel = POS_SPL;
                n_state   = S_SP_DT;
            end
            S_SP_DT: begin
                o_cmd.op = OP_SPL;
                n_state  = i_st.t_gt1 ? S_SP_AD : S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/rtnb_dp.sv
// ----------------------------------------------------------------------------
// rtnb_dp
// Key store, probe address generation, prefix compare and search registers.
// ----------------------------------------------------------------------------
module rtnb_dp
    import rtnb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_st,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_count,
    input  logic             i_func,
    input  logic [IDX_W-1:0] i_index,
    input  logic [KEY_W-1:0] i_key,
    output logic [IDX_W-1:0] o_node_index,
    output logic [IDX_W-1:0] o_left_child,
    output logic             o_left_is_leaf,
    output logic [IDX_W-1:0] o_right_child,
    output logic             o_right_is_leaf,
    output logic             o_duplicate_error
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int W  = ((AW + 4) > 12) ? (AW + 4) : 12;

    logic [CNT_W-1:0]        r_key_count;
    logic signed [W-1:0]     r_i, r_lim, r_len, r_t, r_s;
    logic [KEY_W-1:0]        r_ki;
    logic                    r_inr, r_dneg, r_err;
    logic signed [PFX_W-1:0] r_pa, r_dmin, r_dnode;
    logic [IDX_W-1:0]        r_o_node, r_o_left, r_o_right;
    logic                    r_o_lleaf, r_o_rleaf, r_o_err;

    logic signed [W-1:0]     cnt, m, pos, idx_w, j, split, lo, hi;
    logic                    inr, we;
    logic [AW-1:0]           raddr;
    logic [KEY_W-1:0]        rdata;
    logic signed [PFX_W-1:0] pfx;

    // Effective key count, clipped to the store depth.
    always_comb begin
        if ((W)'(r_key_count) > (W)'(MAX_KEYS)) begin
            cnt = (W)'(MAX_KEYS);
        end else begin
            cnt = (W)'(r_key_count);
        end
    end

    assign idx_w = (W)'(i_index);

    // Probe position: node index plus or minus the selected offset.
    always_comb begin
        case (i_cmd.sel)
            POS_LIM: m = r_lim;
            POS_FAR: m = r_len + r_t;
            POS_J:   m = r_len;
            POS_SPL: m = r_s + r_t;
            default: m = '0;
        endcase
        case (i_cmd.sel)
            POS_P1:  pos = r_i + (W)'(1);
            POS_M1:  pos = r_i - (W)'(1);
            POS_I:   pos = r_i;
            default: pos = r_dneg ? (r_i - m) : (r_i + m);
        endcase
    end

    assign inr   = (pos >= 0) && (pos < cnt);
    assign raddr = pos[AW-1:0];
    assign we    = (i_cmd.op == OP_ACCEPT) && (i_func == FUNC_LOAD)
                   && ((W)'(i_index) < (W)'(MAX_KEYS));

    rtnb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_index[AW-1:0] & {AW{1'b1}}),
        .i_wdata (i_key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Prefix length of the probed key, minus one when out of range.
    assign pfx = r_inr ? prefix_len(r_ki, rdata) : -(PFX_W)'(1);

    // Status for the controller.
    assign o_st.node_ok   = (idx_w + (W)'(1)) < cnt;
    assign o_st.is_build  = (i_func == FUNC_BUILD);
    assign o_st.dir_zero  = (pfx == r_pa);
    assign o_st.hit_dmin  = (pfx > r_dmin);
    assign o_st.hit_dnode = (pfx > r_dnode);
    assign o_st.t_gt1     = (r_t > (W)'(1));

    // Far end, split and child leaf checks.
    assign j     = r_dneg ? (r_i - r_len) : (r_i + r_len);
    assign split = r_dneg ? (r_i - r_s - (W)'(1)) : (r_i + r_s);
    assign lo    = (r_i < j) ? r_i : j;
    assign hi    = (r_i > j) ? r_i : j;

    // Key count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RST;
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_count;
        end
    end

    // Search registers, updated on controller operations.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_i <= idx_w;
            end
            OP_RD_KI: begin
                r_inr <= 1'b1;
            end
            OP_LATCH_KI: begin
                r_ki <= rdata;
            end
            OP_PROBE: begin
                r_inr <= inr;
            end
            OP_DIR_A: begin
                r_pa <= pfx;
            end
            OP_DIR_B: begin
                r_err  <= (pfx == r_pa);
                r_dneg <= (r_pa < pfx);
                r_dmin <= (r_pa < pfx) ? r_pa : pfx;
                r_lim  <= (W)'(2);
            end
            OP_LIM: begin
                if (pfx > r_dmin) begin
                    r_lim <= r_lim <<< 2;
                end else begin
                    r_t   <= r_lim >>> 1;
                    r_len <= '0;
                end
            end
            OP_FAR: begin
                if (pfx > r_dmin) begin
                    r_len <= r_len + r_t;
                end
                r_t <= r_t >>> 1;
            end
            OP_DN: begin
                r_dnode <= pfx;
                r_s     <= '0;
                r_t     <= (r_len + (W)'(1)) >>> 1;
            end
            OP_SPL: begin
                if (pfx > r_dnode) begin
                    r_s <= r_s + r_t;
                end
                if (r_t > (W)'(1)) begin
                    r_t <= (r_t + (W)'(1)) >>> 1;
                end
            end
            OP_OUT: begin
                r_o_node <= r_i[IDX_W-1:0];
                r_o_err  <= r_err;
                if (r_err) begin
                    r_o_left  <= '0;
                    r_o_right <= '0;
                    r_o_lleaf <= 1'b0;
                    r_o_rleaf <= 1'b0;
                end else begin
                    r_o_left  <= split[IDX_W-1:0];
                    r_o_right <= split[IDX_W-1:0] + IDX_W'(1);
                    r_o_lleaf <= (lo == split);
                    r_o_rleaf <= (hi == split + (W)'(1));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_node_index      = r_o_node;
    assign o_left_child      = r_o_left;
    assign o_left_is_leaf    = r_o_lleaf;
    assign o_right_child     = r_o_right;
    assign o_right_is_leaf   = r_o_rleaf;
    assign o_duplicate_error = r_o_err;

endmodule

// File: rtl/radix_tree_node_builder_top.sv
// ----------------------------------------------------------------------------
// radix_tree_node_builder_top
// Binary radix tree node builder over a store of sorted 64-bit Morton keys.
//
// Channel    Dir  Beat contents
// i_item     in   func, index, key
// o_result   out  node_index, left/right child with leaf flags, duplicate_error
// i_cfg      in   key_count
//
// A load beat is accepted without leaving idle. A build beat holds the input
// side from acceptance until its result is registered, through B bound, F
// far-end and S split probes (B about log4, F and S about log2 of
// key_count); every probe is one key RAM read plus one prefix compare. Equal
// neighbor prefixes end a build after the direction probes. A finished build
// waits while the output register still holds an untaken result; a result
// waits there while the next item is accepted. Reset clears control state
// and sets key_count to 2; the key store is not cleared.
// ----------------------------------------------------------------------------
module radix_tree_node_builder_top
    import rtnb_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    rtnb_in_if.sink      i_item,
    rtnb_out_if.source   o_result,
    rtnb_cfg_if.sink     i_cfg
);

`include "radix_tree_node_builder_top_assert.svh"

    t_cmd  cmd;
    t_stat st;

    // Configuration beats are taken whenever the block is out of reset.
    assign i_cfg.ready = i_rst_n;

    rtnb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    rtnb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_st              (st),
        .i_cfg_we          (i_cfg.valid && i_cfg.ready),
        .i_cfg_count       (i_cfg.key_count),
        .i_func            (i_item.func),
        .i_index           (i_item.index),
        .i_key             (i_item.key),
        .o_node_index      (o_result.node_index),
        .o_left_child      (o_result.left_child),
        .o_left_is_leaf    (o_result.left_is_leaf),
        .o_right_child     (o_result.right_child),
        .o_right_is_leaf   (o_result.right_is_leaf),
        .o_duplicate_error (o_result.duplicate_error)
    );

    // Children of a good node are adjacent; an error result has no children.
    `RTNB_ASSERT_NOW(a_adjacent, i_clk, i_rst_n,
        o_result.valid && !o_result.duplicate_error,
        o_result.right_child == o_result.left_child + 10'd1, "children not adjacent")
    `RTNB_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        o_result.valid && o_result.duplicate_error,
        o_result.left_child == 10'd0 && o_result.right_child == 10'd0, "error with children")
    // An accepted in-range build keeps the input side busy.
    `RTNB_ASSERT_NXT(a_build_busy, i_clk, i_rst_n,
        i_item.valid && i_item.ready && st.is_build && st.node_ok,
        !i_item.ready, "build did not start")

endmodule
